// ===== hw/rtl/sequenced_mailbox_queue_core_macros.svh =====
// assertion macros for the sequenced mailbox queue checker
// expects clk and rst in the scope of use
`ifndef SEQUENCED_MAILBOX_QUEUE_CORE_MACROS_SVH
`define SEQUENCED_MAILBOX_QUEUE_CORE_MACROS_SVH

// checked outside reset
`define SMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset too
`define SMQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/smq_pkg.sv =====
// shared types and constants for the sequenced mailbox queue
// no dependencies
package smq_pkg;

  localparam int QUEUE_DEPTH_DEF = 10;
  localparam int MAX_PACKET_DEF  = 512;
  localparam int SEQ_W           = 32;
  localparam int PLEN_W          = 10;
  localparam int OFF_W           = 9;
  localparam int BYTE_W          = 8;
  localparam int STATUS_W        = 2;

  typedef enum logic [2:0] {
    CMD_STAGE      = 3'd0,
    CMD_COMMIT     = 3'd1,
    CMD_SELECT     = 3'd2,
    CMD_READ       = 3'd3,
    CMD_CONNECT    = 3'd4,
    CMD_DISCONNECT = 3'd5,
    CMD_SET_CURSOR = 3'd6,
    CMD_QUERY      = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_DROPPED = 2'd1,
    STATUS_NONE    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_SEARCH,
    ST_RD_WAIT,
    ST_FINISH
  } state_t;

endpackage

// ===== hw/rtl/sequenced_mailbox_queue_core.sv =====
// sequenced mailbox queue: packet staging, drop-oldest slot ring, sequenced reads
// depends on smq_pkg
//
// usage:
//   input beats on s_axis: tuser carries the command, tdata the byte, offset
//   and cursor value. every accepted beat returns exactly one result beat on
//   m_axis (status and notify in tuser, length, number and byte in tdata).
//   cfg_wr_en/cfg_wr_data write the enable bit; writing zero drops the link.
//   one beat is processed at a time; s_axis_tready is high only when idle.
//   stage, connect, disconnect, cursor and query beats, a discarded commit and a bad
//   read go straight to finish; a good read passes a read wait step. a stored commit
//   copies the staged bytes one per cycle through the stage memory read port. a select
//   walks the ring with one shared compare, one slot per cycle, until a hit or the end.
//   results sit in an output register; the next beat is taken while it
//   waits, and the block holds in its finish step while m_axis is stalled.
//   reset (synchronous) clears the ring, the selection, the stage length,
//   sets sequence and cursor to one and disables the link; no clearing pass.
module sequenced_mailbox_queue_core
  import smq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int MAX_PACKET  = MAX_PACKET_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,      // link_enabled
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,     // data_byte, byte_offset, cursor_value
  input  logic [2:0]  s_axis_tuser,     // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,     // packet_length, seq_number, read_data
  output logic [2:0]  m_axis_tuser      // status, notify
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W = $clog2(MAX_PACKET + 1);
  localparam int SA_W  = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;
  localparam int SM_D  = QUEUE_DEPTH * MAX_PACKET;
  localparam int SM_W  = (SM_D > 1) ? $clog2(SM_D) : 1;
  localparam int CMP_W = (LEN_W > OFF_W) ? LEN_W : OFF_W;

  state_t state, state_next;

  logic link_enabled, link_connected;
  logic [LEN_W-1:0] stage_length;
  logic             stage_oversize;
  logic [BYTE_W-1:0] stage_mem [MAX_PACKET];
  logic [BYTE_W-1:0] slot_mem [SM_D];
  logic [LEN_W-1:0]  slot_length [QUEUE_DEPTH];
  logic [SEQ_W-1:0]  slot_seq [QUEUE_DEPTH];
  logic [IDX_W-1:0]  ring_head;
  logic [CNT_W-1:0]  ring_count;
  logic [SEQ_W-1:0]  next_seq, read_cursor;

  logic             sel_valid;
  logic [SM_W-1:0]  sel_base;
  logic [LEN_W-1:0] sel_len;
  logic [SEQ_W-1:0] sel_seq;

  logic [LEN_W-1:0]  cp_cnt, cp_wr_off;
  logic              cp_wr_en;
  logic [SM_W-1:0]   cp_base;
  logic [BYTE_W-1:0] stage_q, slot_q;

  logic [IDX_W-1:0] srch_idx;
  logic [CNT_W-1:0] srch_cnt;

  logic [STATUS_W-1:0] res_status;
  logic [PLEN_W-1:0]   res_len;
  logic [SEQ_W-1:0]    res_seq;
  logic [BYTE_W-1:0]   res_rdata;
  logic                res_notify;

  logic         accept, out_load;
  cmd_t         in_cmd;
  logic [BYTE_W-1:0] in_byte;
  logic [OFF_W-1:0]  in_off;
  logic [SEQ_W-1:0]  in_cursor;

  logic             ring_full, commit_ok, off_bad, srch_end, srch_hit;
  logic [IDX_W-1:0] head_adj, wr_idx, srch_idx_inc;
  logic [CNT_W-1:0] count_adj;
  logic [IDX_W:0]   idx_sum;
  logic [SEQ_W-1:0] latest;

  assign in_cmd    = cmd_t'(s_axis_tuser);
  assign in_byte   = s_axis_tdata[7:0];
  assign in_off    = s_axis_tdata[16:8];
  assign in_cursor = s_axis_tdata[48:17];
  assign accept    = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ring_full = (ring_count == CNT_W'(QUEUE_DEPTH));
    if (ring_full) begin
      head_adj  = (ring_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : ring_head + 1'b1;
      count_adj = ring_count - 1'b1;
    end else begin
      head_adj  = ring_head;
      count_adj = ring_count;
    end
    idx_sum = (IDX_W + 1)'(head_adj) + (IDX_W + 1)'(count_adj);
    if (idx_sum >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
      wr_idx = IDX_W'(idx_sum - (IDX_W + 1)'(QUEUE_DEPTH));
    end else begin
      wr_idx = IDX_W'(idx_sum);
    end
    commit_ok    = link_enabled && link_connected && !stage_oversize;
    off_bad      = CMP_W'(in_off) >= CMP_W'(sel_len);
    latest       = (next_seq != '0) ? next_seq - 1'b1 : '0;
    srch_end     = srch_cnt >= ring_count;
    srch_hit     = !srch_end && (slot_seq[srch_idx] >= read_cursor);
    srch_idx_inc = (srch_idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : srch_idx + 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_COMMIT: state_next = commit_ok ? ST_COPY : ST_FINISH;
            CMD_SELECT: state_next = ST_SEARCH;
            CMD_READ:   state_next = (sel_valid && !off_bad) ? ST_RD_WAIT : ST_FINISH;
            default:    state_next = ST_FINISH;
          endcase
        end
      end
      ST_COPY:    if (cp_cnt == stage_length) state_next = ST_FINISH;
      ST_SEARCH:  if (srch_hit || srch_end) state_next = ST_FINISH;
      ST_RD_WAIT: state_next = ST_FINISH;
      ST_FINISH:  if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_FINISH: out_load = !m_axis_tvalid || m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // stage memory
  always_ff @(posedge clk) begin
    if (accept && in_cmd == CMD_STAGE && stage_length < LEN_W'(MAX_PACKET)) begin
      stage_mem[stage_length[SA_W-1:0]] <= in_byte;
    end
    stage_q <= stage_mem[cp_cnt[SA_W-1:0]];
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (cp_wr_en) begin
      slot_mem[cp_base + SM_W'(cp_wr_off)] <= stage_q;
    end
    slot_q <= slot_mem[sel_base + SM_W'(in_off)];
  end

  // copy sweep bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      cp_wr_en <= 1'b0;
    end else begin
      cp_wr_en <= (state == ST_COPY) && (cp_cnt < stage_length);
    end
    cp_wr_off <= cp_cnt;
    if (state == ST_COPY) cp_cnt <= cp_cnt + 1'b1;
    else                  cp_cnt <= '0;
  end

  // control state and results
  always_ff @(posedge clk) begin
    if (rst) begin
      link_enabled   <= 1'b0;
      link_connected <= 1'b0;
      stage_length   <= '0;
      stage_oversize <= 1'b0;
      ring_head      <= '0;
      ring_count     <= '0;
      next_seq       <= SEQ_W'(1);
      read_cursor    <= SEQ_W'(1);
      sel_valid      <= 1'b0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        link_enabled <= cfg_wr_data;
        if (!cfg_wr_data) begin
          link_connected <= 1'b0;
          ring_head      <= '0;
          ring_count     <= '0;
          sel_valid      <= 1'b0;
        end
      end

      if (accept) begin
        res_status <= STATUS_OK;
        res_len    <= '0;
        res_seq    <= '0;
        res_rdata  <= '0;
        res_notify <= 1'b0;
        case (in_cmd)
          CMD_STAGE: begin
            if (stage_length < LEN_W'(MAX_PACKET)) stage_length <= stage_length + 1'b1;
            else                                    stage_oversize <= 1'b1;
          end
          CMD_COMMIT: begin
            if (commit_ok) begin
              ring_head  <= head_adj;
              ring_count <= count_adj + 1'b1;
              if (sel_valid && sel_base == SM_W'(wr_idx) * SM_W'(MAX_PACKET)) begin
                sel_valid <= 1'b0;
              end
              slot_length[wr_idx] <= stage_length;
              slot_seq[wr_idx]    <= next_seq;
              next_seq   <= next_seq + 1'b1;
              cp_base    <= SM_W'(wr_idx) * SM_W'(MAX_PACKET);
              res_len    <= PLEN_W'(stage_length);
              res_seq    <= next_seq;
              res_notify <= 1'b1;
            end else begin
              res_status   <= STATUS_DROPPED;
              stage_length <= '0;
            end
            stage_oversize <= 1'b0;
          end
          CMD_SELECT: begin
            sel_valid <= 1'b0;
            srch_idx  <= ring_head;
            srch_cnt  <= '0;
          end
          CMD_READ: begin
            if (!sel_valid) begin
              res_status <= STATUS_NONE;
            end else begin
              res_len <= PLEN_W'(sel_len);
              res_seq <= sel_seq;
              if (off_bad) res_status <= STATUS_NONE;
            end
          end
          CMD_CONNECT: begin
            link_connected <= 1'b1;
            read_cursor    <= next_seq;
            res_seq        <= latest;
          end
          CMD_DISCONNECT: begin
            link_connected <= 1'b0;
            ring_head      <= '0;
            ring_count     <= '0;
            sel_valid      <= 1'b0;
          end
          CMD_SET_CURSOR: read_cursor <= in_cursor;
          default:        res_seq <= latest;
        endcase
      end

      if (state == ST_COPY && cp_cnt == stage_length) stage_length <= '0;

      if (state == ST_SEARCH) begin
        srch_idx <= srch_idx_inc;
        srch_cnt <= srch_cnt + 1'b1;
        if (srch_hit) begin
          sel_valid   <= 1'b1;
          sel_base    <= SM_W'(srch_idx) * SM_W'(MAX_PACKET);
          sel_len     <= slot_length[srch_idx];
          sel_seq     <= slot_seq[srch_idx];
          read_cursor <= slot_seq[srch_idx] + 1'b1;
          res_len     <= PLEN_W'(slot_length[srch_idx]);
          res_seq     <= slot_seq[srch_idx];
        end else if (srch_end) begin
          res_status <= STATUS_NONE;
        end
      end

      if (state == ST_RD_WAIT) res_rdata <= slot_q;

      if (out_load)           m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {6'd0, res_rdata, res_seq, res_len};
      m_axis_tuser <= {res_notify, res_status};
    end
  end

endmodule

// ===== hw/rtl/smq_checker.sv =====
// port-level checks for the sequenced mailbox queue, bound to the top level
// depends on sequenced_mailbox_queue_core_macros.svh
`include "sequenced_mailbox_queue_core_macros.svh"

module smq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  `SMQ_ASSERT_ALWAYS(a_reset_no_beat, rst |=> !m_axis_tvalid, "result beat right after reset")
  `SMQ_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result beat changed")
  `SMQ_ASSERT(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second beat taken while busy")
  `SMQ_ASSERT(a_notify_ok, m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == 2'd0, "notify with bad status")
  `SMQ_ASSERT(a_status_code, m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3, "unknown status code")

endmodule

bind sequenced_mailbox_queue_core smq_checker u_smq_checker (.*);
